// ===== hw/rtl/gpfc_pkg.sv =====
// Shared types, constants and the logistic membership table for the gait phase classifier.
// Used by every module of the block; depends on nothing else.

package gpfc_pkg;

    localparam int SAMPLE_BITS      = 12;
    localparam int LOGISTIC_ENTRIES = 256;

    localparam int PRESS_W   = 12;
    localparam int TIME_W    = 32;
    localparam int CENTER_W  = 12;
    localparam int SLOPE_W   = 11;
    localparam int LEVEL_W   = 17;
    localparam int STIFF_W   = 16;
    localparam int ANGLE_W   = 7;
    localparam int PHASE_W   = 3;
    localparam int GSUM_W    = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam int Q_W       = 17;
    localparam int MUL_W     = 17;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SCORE_W   = Q_W + 1;
    localparam int DIFF_W    = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
    localparam int MAG_W     = DIFF_W - 1 + SLOPE_W;
    localparam int LUT_BITS  = $clog2(LOGISTIC_ENTRIES);
    localparam int IDX_SHIFT = 11;
    localparam int STEP_W    = 5;

    localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

    localparam logic [63:0] LUT_STEP = (64'd16 << 32) / 64'(LOGISTIC_ENTRIES);

    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFF1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STIFF2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE2 = 3'd6;

    localparam logic [PHASE_W-1:0] PHASE_NONE     = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_CONTACT  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_MID      = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_TERMINAL = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_SWING    = 3'd4;

    typedef struct packed {
        logic start;
        logic out_free;
    } core_ctl_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic [SLOPE_W-1:0]  slope;
        logic [LEVEL_W-1:0]  level;
    } core_cfg_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [PHASE_W-1:0] pick;
    } core_res_t;

    typedef logic [LOGISTIC_ENTRIES-1:0][Q_W-1:0] lut_t;

    // Restoring long division; only used while the constant table is built.
    function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] dvs);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs}) begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Logistic table: exp step as a truncated Taylor series in Q32, then
    // T[i] = round(2^48 / (2^32 + e_i)) with e_i the running Q32 power.
    function automatic lut_t build_lut();
        lut_t        t;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] e;
        logic [63:0] den;
        a    = LUT_STEP;
        term = 64'd1 << 32;
        sum  = 64'd1 << 32;
        e    = 64'd1 << 32;
        for (int k = 1; k <= 20; k++) begin
            term = const_div((term * a) >> 32, 64'(k));
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        for (int i = 0; i < LOGISTIC_ENTRIES; i++) begin
            den  = (64'd1 << 32) + e;
            t[i] = Q_W'(const_div((64'd1 << 48) + (den >> 1), den));
            e    = (e * sum + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam lut_t LOGISTIC_LUT = build_lut();

endpackage

// ===== hw/rtl/gait_phase_fuzzy_classifier.sv =====
// Top level of the gait phase classifier: stream ports, configuration registers,
// held phase, timestamp tracking and the result register. Depends on gpfc_pkg and gpfc_core.
//
//   Channel  Ports                 Beat contents
//   input    s_tvalid/s_tready     four pressure samples and a millisecond timestamp
//   result   m_tvalid/m_tready     phase, stiffness, angle, pressure sum, elapsed time
//   config   cfg_we/cfg_index      one register written per cycle with cfg_we high
//
// An input beat keeps s_tready low until its decision is made, so the next beat waits for it;
// the shared 17x17 multiplier issues four membership and thirteen score products.
// Reset is synchronous and active low; it restores the register defaults and clears the
// held phase and the last timestamp. A result waiting on m_tready does not block the next
// input beat, but the decision of that next item waits until the result register is free.

module gait_phase_fuzzy_classifier
    import gpfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // heel_pressure, meta12_pressure, meta45_pressure, toe_pressure, now_ms
    input  logic [79:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // phase, stiffness, angle, ground_sum, elapsed_ms
    output logic [71:0]          m_tdata,
    // undecided
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    logic [CENTER_W-1:0] center_reg;
    logic [SLOPE_W-1:0]  slope_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [STIFF_W-1:0]  stiff1_reg, stiff2_reg;
    logic [ANGLE_W-1:0]  angle1_reg, angle2_reg;

    logic [PHASE_W-1:0]  held_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [GSUM_W-1:0]   gsum_reg;

    logic                m_valid_reg;
    logic [PHASE_W-1:0]  o_phase_reg;
    logic                o_undec_reg;
    logic [STIFF_W-1:0]  o_stiff_reg;
    logic [ANGLE_W-1:0]  o_angle_reg;
    logic [GSUM_W-1:0]   o_gsum_reg;
    logic [TIME_W-1:0]   o_elapsed_reg;

    logic [SAMPLE_BITS-1:0] heel, meta12, meta45, toe;
    logic [TIME_W-1:0]      now_ms;
    logic [SAMPLE_BITS+1:0] gsum_wide;
    logic                   accept;
    core_ctl_t              ctl;
    core_cfg_t              ccfg;
    core_res_t              res;
    logic [PHASE_W-1:0]     phase_next;
    logic [STIFF_W-1:0]     stiff_next;
    logic [ANGLE_W-1:0]     angle_next;

    assign heel   = SAMPLE_BITS'(s_tdata[PRESS_W-1:0]);
    assign meta12 = SAMPLE_BITS'(s_tdata[2*PRESS_W-1:PRESS_W]);
    assign meta45 = SAMPLE_BITS'(s_tdata[3*PRESS_W-1:2*PRESS_W]);
    assign toe    = SAMPLE_BITS'(s_tdata[4*PRESS_W-1:3*PRESS_W]);
    assign now_ms = s_tdata[4*PRESS_W+TIME_W-1:4*PRESS_W];

    assign gsum_wide = (SAMPLE_BITS+2)'(heel) + (SAMPLE_BITS+2)'(meta12)
                     + (SAMPLE_BITS+2)'(meta45) + (SAMPLE_BITS+2)'(toe);

    assign s_tready = aresetn && !res.busy;
    assign accept   = s_tvalid && s_tready;

    assign ctl.start    = accept;
    assign ctl.out_free = !m_valid_reg || m_tready;
    assign ccfg.center  = center_reg;
    assign ccfg.slope   = slope_reg;
    assign ccfg.level   = level_reg;

    gpfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cfg     (ccfg),
        .heel    (heel),
        .meta12  (meta12),
        .meta45  (meta45),
        .toe     (toe),
        .res     (res)
    );

    always_comb begin
        phase_next = (res.pick != PHASE_NONE) ? res.pick : held_reg;
        case (phase_next)
            PHASE_CONTACT: begin stiff_next = stiff1_reg; angle_next = angle1_reg; end
            PHASE_MID:     begin stiff_next = stiff2_reg; angle_next = angle2_reg; end
            default:       begin stiff_next = '0;         angle_next = '0;         end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= CENTER_W'(40);
            slope_reg     <= SLOPE_W'(128);
            level_reg     <= LEVEL_W'(52429);
            stiff1_reg    <= STIFF_W'(70);
            stiff2_reg    <= STIFF_W'(402);
            angle1_reg    <= ANGLE_W'(14);
            angle2_reg    <= ANGLE_W'(12);
            held_reg      <= PHASE_NONE;
            last_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CENTER: center_reg <= cfg_wdata[CENTER_W-1:0];
                    REG_SLOPE:  slope_reg  <= cfg_wdata[SLOPE_W-1:0];
                    REG_LEVEL:  level_reg  <= cfg_wdata[LEVEL_W-1:0];
                    REG_STIFF1: stiff1_reg <= cfg_wdata[STIFF_W-1:0];
                    REG_STIFF2: stiff2_reg <= cfg_wdata[STIFF_W-1:0];
                    REG_ANGLE1: angle1_reg <= cfg_wdata[ANGLE_W-1:0];
                    REG_ANGLE2: angle2_reg <= cfg_wdata[ANGLE_W-1:0];
                    default:    begin end
                endcase
            end
            if (accept) begin
                last_time_reg <= now_ms;
            end
            if (res.done) begin
                held_reg    <= phase_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            elapsed_reg <= now_ms - last_time_reg;
            gsum_reg    <= GSUM_W'(gsum_wide);
        end
        if (res.done) begin
            o_phase_reg   <= phase_next;
            o_undec_reg   <= (res.pick == PHASE_NONE);
            o_stiff_reg   <= stiff_next;
            o_angle_reg   <= angle_next;
            o_gsum_reg    <= gsum_reg;
            o_elapsed_reg <= elapsed_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_undec_reg;
    assign m_tdata  = {o_elapsed_reg, o_gsum_reg, o_angle_reg, o_stiff_reg, o_phase_reg};

endmodule

// ===== hw/rtl/gpfc_mult.sv =====
// Shared unsigned multiplier with a registered product for the gait phase classifier.
// Depends on gpfc_pkg.

module gpfc_mult
    import gpfc_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [MUL_W-1:0]  op_a,
    input  logic [MUL_W-1:0]  op_b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/gpfc_member.sv =====
// Logistic membership lookup: scales the slope product to a table index, clamps it
// and mirrors the entry for negative offsets. Depends on gpfc_pkg.

module gpfc_member
    import gpfc_pkg::*;
(
    input  logic [MAG_W-1:0] mag,
    input  logic             neg,
    output logic [Q_W-1:0]   memb
);

    logic [MAG_W+LUT_BITS-1:0] scaled;
    logic [LUT_BITS-1:0]       idx;
    logic [Q_W-1:0]            entry;

    always_comb begin
        scaled = {mag, {LUT_BITS{1'b0}}} >> IDX_SHIFT;
        if (scaled > (MAG_W + LUT_BITS)'(LOGISTIC_ENTRIES - 1)) begin
            idx = {LUT_BITS{1'b1}};
        end else begin
            idx = scaled[LUT_BITS-1:0];
        end
        entry = LOGISTIC_LUT[idx];
        memb  = neg ? (ONE_Q16 - entry) : entry;
    end

endmodule

// ===== hw/rtl/gpfc_core.sv =====
// Sequencer and score datapath: drives the shared multiplier through the four
// memberships and thirteen score products, then picks a phase. Depends on gpfc_pkg,
// gpfc_mult and gpfc_member.

module gpfc_core
    import gpfc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  core_ctl_t              ctl,
    input  core_cfg_t              cfg,
    input  logic [SAMPLE_BITS-1:0] heel,
    input  logic [SAMPLE_BITS-1:0] meta12,
    input  logic [SAMPLE_BITS-1:0] meta45,
    input  logic [SAMPLE_BITS-1:0] toe,
    output core_res_t              res
);

    localparam logic [STEP_W-1:0] ST_DECIDE = STEP_W'(18);
    localparam logic [STEP_W-1:0] ST_LAST_ISSUE = STEP_W'(16);

    logic                   busy_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [SAMPLE_BITS-1:0] heel_reg, m12_reg, m45_reg, toe_reg;
    logic                   neg_reg;
    logic [Q_W-1:0]         hl_reg, al_reg, bl_reg, tl_reg;
    logic [Q_W-1:0]         s1_reg, s2_reg, s3_reg, s4_reg;
    logic [Q_W-1:0]         ic1_reg, lr1_reg, ms_reg, s4b_reg, sw_reg;
    logic [SCORE_W-1:0]     sc1_reg, sc3_reg;

    logic [Q_W-1:0]         hs, as_, bs, ts_;
    logic [SAMPLE_BITS-1:0] cur_sample;
    logic [DIFF_W-1:0]      diff;
    logic [DIFF_W-2:0]      absd;
    logic [MUL_W-1:0]       op_a, op_b;
    logic [PROD_W-1:0]      prod;
    logic [Q_W-1:0]         qprod;
    logic [Q_W-1:0]         memb;
    logic                   decide;
    logic [PHASE_W-1:0]     pick;

    assign hs  = ONE_Q16 - hl_reg;
    assign as_ = ONE_Q16 - al_reg;
    assign bs  = ONE_Q16 - bl_reg;
    assign ts_ = ONE_Q16 - tl_reg;

    always_comb begin
        case (step_reg[1:0])
            2'd0:    cur_sample = heel_reg;
            2'd1:    cur_sample = m45_reg;
            2'd2:    cur_sample = m12_reg;
            default: cur_sample = toe_reg;
        endcase
        diff = DIFF_W'(cur_sample) - DIFF_W'(cfg.center);
        absd = diff[DIFF_W-1] ? (DIFF_W-1)'(-diff) : diff[DIFF_W-2:0];
    end

    always_comb begin
        op_a = MUL_W'(absd);
        op_b = MUL_W'(cfg.slope);
        case (step_reg)
            5'd4:    begin op_a = hl_reg;  op_b = as_;    end
            5'd5:    begin op_a = hl_reg;  op_b = al_reg; end
            5'd6:    begin op_a = hs;      op_b = al_reg; end
            5'd7:    begin op_a = hs;      op_b = as_;    end
            5'd8:    begin op_a = s1_reg;  op_b = bs;     end
            5'd9:    begin op_a = s2_reg;  op_b = bs;     end
            5'd10:   begin op_a = s2_reg;  op_b = bl_reg; end
            5'd11:   begin op_a = s3_reg;  op_b = bl_reg; end
            5'd12:   begin op_a = s4_reg;  op_b = bs;     end
            5'd13:   begin op_a = ic1_reg; op_b = ts_;    end
            5'd14:   begin op_a = lr1_reg; op_b = ts_;    end
            5'd15:   begin op_a = s4b_reg; op_b = tl_reg; end
            5'd16:   begin op_a = s4b_reg; op_b = ts_;    end
            default: begin end
        endcase
    end

    gpfc_mult u_mult (
        .aclk (aclk),
        .en   (busy_reg),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign qprod = prod[Q_W+15:16];

    gpfc_member u_member (
        .mag  (prod[MAG_W-1:0]),
        .neg  (neg_reg),
        .memb (memb)
    );

    always_comb begin
        pick = PHASE_NONE;
        if (sc1_reg >= SCORE_W'(cfg.level)) begin
            pick = PHASE_CONTACT;
        end else if (ms_reg >= cfg.level) begin
            pick = PHASE_MID;
        end else if (sc3_reg >= SCORE_W'(cfg.level)) begin
            pick = PHASE_TERMINAL;
        end else if (sw_reg >= cfg.level) begin
            pick = PHASE_SWING;
        end
    end

    assign decide   = busy_reg && (step_reg == ST_DECIDE) && ctl.out_free;
    assign res.busy = busy_reg;
    assign res.done = decide;
    assign res.pick = pick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg != ST_DECIDE) begin
                step_reg <= step_reg + STEP_W'(1);
            end else if (ctl.out_free) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            heel_reg <= heel;
            m12_reg  <= meta12;
            m45_reg  <= meta45;
            toe_reg  <= toe;
        end
        if (busy_reg) begin
            neg_reg <= diff[DIFF_W-1];
            case (step_reg)
                5'd1:    hl_reg  <= memb;
                5'd2:    al_reg  <= memb;
                5'd3:    bl_reg  <= memb;
                5'd4:    tl_reg  <= memb;
                5'd5:    s1_reg  <= qprod;
                5'd6:    s2_reg  <= qprod;
                5'd7:    s3_reg  <= qprod;
                5'd8:    s4_reg  <= qprod;
                5'd9:    ic1_reg <= qprod;
                5'd10:   lr1_reg <= qprod;
                5'd11:   ms_reg  <= qprod;
                5'd12:   sc3_reg <= SCORE_W'(qprod);
                5'd13:   s4b_reg <= qprod;
                5'd14:   sc1_reg <= SCORE_W'(qprod);
                5'd15:   sc1_reg <= sc1_reg + SCORE_W'(qprod);
                5'd16:   sc3_reg <= sc3_reg + SCORE_W'(qprod);
                5'd17:   sw_reg  <= qprod;
                default: begin end
            endcase
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> !busy_reg)
        else $error("Item started while the sequencer is busy.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg && (step_reg == '0))
        else $error("Sequencer did not begin at the first step.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (step_reg <= ST_LAST_ISSUE) |=> busy_reg
            && (step_reg == $past(step_reg) + STEP_W'(1)))
        else $error("Sequencer skipped or repeated a multiply step.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && (step_reg == ST_DECIDE) && !ctl.out_free |=> busy_reg
            && (step_reg == ST_DECIDE))
        else $error("Decision was lost while the result slot was full.");
`endif

endmodule

// ===== bench/tb_gait_phase_fuzzy_classifier.sv =====
// Self-checking testbench for gait_phase_fuzzy_classifier: insole beats in, phase results out.
// Holds its own predictor, drives random stalls on both streams and sweeps the registers.
// Depends on gpfc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_gait_phase_fuzzy_classifier;
    import gpfc_pkg::*;

    typedef struct {
        bit [11:0] heel;
        bit [11:0] m12;
        bit [11:0] m45;
        bit [11:0] toe;
        bit [31:0] now_ms;
    } insole_item_t;

    typedef struct {
        bit [PHASE_W-1:0] phase;
        bit               undecided;
        bit [15:0]        stiffness;
        bit [6:0]         angle;
        bit [13:0]        ground_sum;
        bit [31:0]        elapsed_ms;
    } gait_result_t;

    localparam bit [3:0] GAIT_SHAPE [6] = '{4'b1000, 4'b1010, 4'b1110, 4'b0110, 4'b0001,
                                            4'b0000};

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [79:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [71:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    bit [16:0]        sigmoid_tab [LOGISTIC_ENTRIES];
    bit [11:0]        cfg_center = 12'd40;
    bit [10:0]        cfg_slope = 11'd128;
    bit [16:0]        cfg_level = 17'd52429;
    bit [15:0]        cfg_stiff1 = 16'd70;
    bit [15:0]        cfg_stiff2 = 16'd402;
    bit [6:0]         cfg_angle1 = 7'd14;
    bit [6:0]         cfg_angle2 = 7'd12;
    bit [PHASE_W-1:0] gait_held = PHASE_NONE;
    bit [31:0]        gait_last_ms = '0;

    insole_item_t pending_q [$];
    gait_result_t phase_expect_q [$];
    insole_item_t drv_item;
    bit           drv_load;
    int           in_gap = 0;
    int           out_gap = 0;
    int           in_gap_max = 12;
    int           out_gap_max = 12;
    int           beats_queued = 0;
    int           beats_in = 0;
    int           beats_out = 0;
    int           settings_run = 1;
    int           undecided_seen = 0;
    int           phase_seen [5];
    int           errors = 0;
    int           gait_step = 0;
    bit [31:0]    clock_ms = '0;

    gait_phase_fuzzy_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void fill_sigmoid_tab();
        bit [63:0] step;
        bit [63:0] term;
        bit [63:0] decay;
        bit [63:0] pw;
        bit [63:0] den;
        step  = (64'd16 << 32) / 64'(LOGISTIC_ENTRIES);
        term  = 64'd1 << 32;
        decay = 64'd1 << 32;
        pw    = 64'd1 << 32;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * step) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                decay = decay - term;
            end else begin
                decay = decay + term;
            end
        end
        for (int i = 0; i < LOGISTIC_ENTRIES; i++) begin
            den             = (64'd1 << 32) + pw;
            sigmoid_tab[i]  = 17'(((64'd1 << 48) + den / 2) / den);
            pw              = (pw * decay + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic bit [63:0] membership(bit [11:0] x);
        longint    diff;
        bit [63:0] idx;
        diff = longint'(x) - longint'(cfg_center);
        idx  = ((64'(diff < 0 ? -diff : diff) * 64'(cfg_slope)) * LOGISTIC_ENTRIES) >> 11;
        if (idx > LOGISTIC_ENTRIES - 1) begin
            idx = LOGISTIC_ENTRIES - 1;
        end
        return diff < 0 ? 64'd65536 - sigmoid_tab[idx] : 64'(sigmoid_tab[idx]);
    endfunction

    function automatic bit [63:0] qmul16(bit [63:0] a, bit [63:0] b);
        return (a * b) >> 16;
    endfunction

    function automatic gait_result_t classify_gait(insole_item_t it);
        gait_result_t     r;
        bit [63:0]        heel_hi, heel_lo, m45_hi, m45_lo, m12_hi, m12_lo, toe_hi, toe_lo;
        bit [63:0]        sc_ic, sc_lr, sc_ms, sc_ts, sc_ps, sc_sw;
        bit [PHASE_W-1:0] pick;
        heel_hi = membership(it.heel);
        heel_lo = 64'd65536 - heel_hi;
        m45_hi  = membership(it.m45);
        m45_lo  = 64'd65536 - m45_hi;
        m12_hi  = membership(it.m12);
        m12_lo  = 64'd65536 - m12_hi;
        toe_hi  = membership(it.toe);
        toe_lo  = 64'd65536 - toe_hi;
        sc_ic = qmul16(qmul16(qmul16(heel_hi, m45_lo), m12_lo), toe_lo);
        sc_lr = qmul16(qmul16(qmul16(heel_hi, m45_hi), m12_lo), toe_lo);
        sc_ms = qmul16(qmul16(heel_hi, m45_hi), m12_hi);
        sc_ts = qmul16(qmul16(heel_lo, m45_hi), m12_hi);
        sc_ps = qmul16(qmul16(qmul16(heel_lo, m45_lo), m12_lo), toe_hi);
        sc_sw = qmul16(qmul16(qmul16(heel_lo, m45_lo), m12_lo), toe_lo);
        if (sc_ic + sc_lr >= cfg_level) begin
            pick = PHASE_CONTACT;
        end else if (sc_ms >= cfg_level) begin
            pick = PHASE_MID;
        end else if (sc_ts + sc_ps >= cfg_level) begin
            pick = PHASE_TERMINAL;
        end else if (sc_sw >= cfg_level) begin
            pick = PHASE_SWING;
        end else begin
            pick = PHASE_NONE;
        end
        if (pick != PHASE_NONE) begin
            gait_held = pick;
        end
        r.phase     = gait_held;
        r.undecided = (pick == PHASE_NONE);
        r.stiffness = '0;
        r.angle     = '0;
        if (gait_held == PHASE_CONTACT) begin
            r.stiffness = cfg_stiff1;
            r.angle     = cfg_angle1;
        end else if (gait_held == PHASE_MID) begin
            r.stiffness = cfg_stiff2;
            r.angle     = cfg_angle2;
        end
        r.ground_sum = 14'(it.heel) + 14'(it.m12) + 14'(it.m45) + 14'(it.toe);
        r.elapsed_ms = it.now_ms - gait_last_ms;
        gait_last_ms = it.now_ms;
        return r;
    endfunction

    function automatic int draw_gap(int top);
        return (top == 0) ? 0 : int'($urandom_range(top, 0));
    endfunction

    task automatic log_error(string msg);
        errors++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    task automatic check_result(logic [71:0] data, logic flag);
        gait_result_t want;
        if (phase_expect_q.size() == 0) begin
            log_error($sformatf("result beat %0d arrived with nothing expected", beats_out));
            return;
        end
        want = phase_expect_q.pop_front();
        if (data[2:0] !== want.phase)
            log_error($sformatf("beat %0d phase %0d, expected %0d",
                                beats_out, data[2:0], want.phase));
        if (flag !== want.undecided)
            log_error($sformatf("beat %0d undecided %0b, expected %0b",
                                beats_out, flag, want.undecided));
        if (data[18:3] !== want.stiffness)
            log_error($sformatf("beat %0d stiffness %0d, expected %0d",
                                beats_out, data[18:3], want.stiffness));
        if (data[25:19] !== want.angle)
            log_error($sformatf("beat %0d angle %0d, expected %0d",
                                beats_out, data[25:19], want.angle));
        if (data[39:26] !== want.ground_sum)
            log_error($sformatf("beat %0d ground_sum %0d, expected %0d",
                                beats_out, data[39:26], want.ground_sum));
        if (data[71:40] !== want.elapsed_ms)
            log_error($sformatf("beat %0d elapsed_ms %0h, expected %0h",
                                beats_out, data[71:40], want.elapsed_ms));
        if (want.undecided) begin
            undecided_seen++;
        end
        phase_seen[want.phase]++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            in_gap = draw_gap(in_gap_max);
        end else begin
            drv_load = !s_tvalid;
            if (s_tvalid && s_tready) begin
                phase_expect_q.push_back(classify_gait(drv_item));
                beats_in++;
                in_gap   = draw_gap(in_gap_max);
                drv_load = 1'b1;
            end
            if (drv_load) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    drv_item = pending_q.pop_front();
                    s_tdata  <= {drv_item.now_ms, drv_item.toe, drv_item.m45, drv_item.m12,
                                 drv_item.heel};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata, m_tuser);
                beats_out++;
                out_gap = draw_gap(out_gap_max);
            end
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_item(bit [11:0] heel, bit [11:0] m12, bit [11:0] m45,
                              bit [11:0] toe, bit [31:0] now_ms);
        insole_item_t it;
        it.heel   = heel;
        it.m12    = m12;
        it.m45    = m45;
        it.toe    = toe;
        it.now_ms = now_ms;
        pending_q.push_back(it);
        beats_queued++;
    endtask

    function automatic bit [11:0] pick_sample(bit hi);
        return hi ? 12'($urandom_range(4095, cfg_center)) : 12'($urandom_range(cfg_center, 0));
    endfunction

    function automatic bit [11:0] near_center();
        int v;
        v = int'(cfg_center) + int'($urandom_range(8, 0)) - 4;
        return 12'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
    endfunction

    task automatic random_items(int count);
        bit [3:0]  shape;
        bit [11:0] smp [4];
        int        roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99, 0);
            if (roll < 70) begin
                if ($urandom_range(9, 0) < 4) begin
                    gait_step = (gait_step + 1) % 6;
                end
                shape = GAIT_SHAPE[gait_step];
                if (gait_step == 2 || gait_step == 3) begin
                    shape[0] = 1'($urandom_range(1, 0));
                end
                if ($urandom_range(9, 0) == 0) begin
                    shape[$urandom_range(3, 0)] ^= 1'b1;
                end
                for (int j = 0; j < 4; j++) begin
                    smp[j] = pick_sample(shape[3-j]);
                end
            end else if (roll < 85) begin
                for (int j = 0; j < 4; j++) begin
                    smp[j] = near_center();
                end
            end else begin
                for (int j = 0; j < 4; j++) begin
                    smp[j] = 12'($urandom());
                end
            end
            if ($urandom_range(9, 0) < 8) begin
                clock_ms += $urandom_range(20, 0);
            end else begin
                clock_ms = $urandom();
            end
            queue_item(smp[0], smp[1], smp[2], smp[3], clock_ms);
        end
    endtask

    task automatic wait_idle();
        while (beats_queued != beats_in || beats_out != beats_in) begin
            @(negedge aclk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DAT_W'(val);
        case (idx)
            REG_CENTER: cfg_center = 12'(val);
            REG_SLOPE:  cfg_slope  = 11'(val);
            REG_LEVEL:  cfg_level  = 17'(val);
            REG_STIFF1: cfg_stiff1 = 16'(val);
            REG_STIFF2: cfg_stiff2 = 16'(val);
            REG_ANGLE1: cfg_angle1 = 7'(val);
            REG_ANGLE2: cfg_angle2 = 7'(val);
            default: ;
        endcase
    endtask

    task automatic run_setting(int unsigned center, int unsigned slope, int unsigned level,
                               int unsigned st1, int unsigned st2, int unsigned a1,
                               int unsigned a2, int in_max, int out_max, int count);
        wait_idle();
        cfg_write(REG_CENTER, center);
        cfg_write(REG_SLOPE, slope);
        cfg_write(REG_LEVEL, level);
        cfg_write(REG_STIFF1, st1);
        cfg_write(REG_STIFF2, st2);
        cfg_write(REG_ANGLE1, a1);
        cfg_write(REG_ANGLE2, a2);
        @(posedge aclk);
        cfg_we      <= 1'b0;
        in_gap_max  = in_max;
        out_gap_max = out_max;
        settings_run++;
        random_items(count);
    endtask

    initial begin
        fill_sigmoid_tab();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset register values (center 40).
        queue_item(12'd40, 12'd40, 12'd40, 12'd40, 32'd0);
        queue_item(12'd40, 12'd40, 12'd40, 12'd40, 32'd5);
        queue_item(12'hFFF, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF);
        queue_item(12'hFFF, 12'd0, 12'hFFF, 12'd0, 32'd3);
        queue_item(12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 32'd4);
        queue_item(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd4);
        queue_item(12'd0, 12'hFFF, 12'hFFF, 12'd0, 32'd100);
        queue_item(12'd0, 12'd0, 12'd0, 12'hFFF, 32'd101);
        queue_item(12'd0, 12'd0, 12'd0, 12'd0, 32'd102);
        queue_item(12'd40, 12'd40, 12'd40, 12'd40, 32'd103);
        queue_item(12'hFFF, 12'd40, 12'd40, 12'd40, 32'd104);
        queue_item(12'hAAA, 12'h555, 12'hAAA, 12'h555, 32'hAAAA_AAAA);
        queue_item(12'h555, 12'hAAA, 12'h555, 12'hAAA, 32'h5555_5555);
        queue_item(12'hFFF, 12'd0, 12'd0, 12'd0, 32'h5555_5556);
        queue_item(12'd41, 12'd39, 12'd39, 12'd39, 32'h8000_0000);
        queue_item(12'd39, 12'd41, 12'd41, 12'd39, 32'h7FFF_FFFF);
        queue_item(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'd0);
        clock_ms = 32'd0;
        random_items(300);

        run_setting(0, 1024, 65536, 65535, 0, 90, 0, 0, 0, 200);
        run_setting(4095, 1, 0, 0, 65535, 0, 90, 12, 0, 150);
        run_setting(2048, 2047, 131071, 1234, 4321, 127, 127, 0, 12, 100);
        run_setting(1000, 0, 8192, 65535, 65535, 127, 0, 12, 12, 100);
        for (int r = 0; r < 4; r++) begin
            run_setting($urandom_range(3000, 10), $urandom_range(1024, 1),
                        $urandom_range(65536, 16384), $urandom_range(65535, 0),
                        $urandom_range(65535, 0), $urandom_range(90, 0),
                        $urandom_range(90, 0), (r % 2) * 12, (r / 2) * 12, 170);
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("Ran %0d insole beats and checked %0d results across %0d register settings.",
                 beats_in, beats_out, settings_run);
        $display("Phases none/contact/mid/terminal/swing: %0d/%0d/%0d/%0d/%0d, %0d undecided.",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4],
                 undecided_seen);
        if (errors == 0 && phase_expect_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
